@@ sv/bmp_pkg.sv @@
// Shared widths and reset constants for the binomial-modulo-prime block.
package bmp_pkg;

    localparam int unsigned ARG_W       = 32;
    localparam int unsigned RES_W       = 16;
    localparam int unsigned TABLE_DEPTH = 65536;
    localparam logic [RES_W-1:0] MODULUS_RESET = 16'd65521;

endpackage

@@ sv/bmp_if.sv @@
// Request and response channel interfaces.
interface bmp_req_if;
    logic                          valid;
    logic                          ready;
    logic signed [bmp_pkg::ARG_W-1:0] top_n;
    logic signed [bmp_pkg::ARG_W-1:0] choose_k;

    modport source (output valid, output top_n, output choose_k, input ready);
    modport sink   (input valid, input top_n, input choose_k, output ready);
endinterface

interface bmp_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bmp_pkg::RES_W-1:0]  binomial_residue;

    modport source (output valid, output binomial_residue, input ready);
    modport sink   (input valid, input binomial_residue, output ready);
endinterface

@@ sv/binomial_mod_prime.sv @@
// Top level: C(n,k) mod p via factorial splitting, table of i! mod p and Euclid inverse.
//
//  channel   | dir | payload
//  in_req    | in  | top_n, choose_k (signed 32)
//  out_rsp   | out | binomial_residue (16)
//  cfg       | in  | cfg_wen, cfg_wdata (modulus)
//
// One request at a time; every division goes through the one serial divider.
// Invalid arguments or p below two go straight to the finish state.
// The first valid query after reset or a modulus write first rebuilds the table
// of min(p, TABLE_DEPTH) entries.
// A finished result waits in the output register; the next request is taken meanwhile.
module binomial_mod_prime
#(
    parameter int unsigned TABLE_DEPTH = bmp_pkg::TABLE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    bmp_req_if.sink                    in_req,
    bmp_rsp_if.source                  out_rsp,
    input  logic                       cfg_wen,
    input  logic [bmp_pkg::RES_W-1:0]  cfg_wdata
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned IW = bmp_pkg::RES_W + 1;
    localparam int unsigned XW = AW + IW;
    localparam int unsigned SW = bmp_pkg::RES_W + 2;

    typedef enum logic [20:0] {
        S_IDLE   = 21'h000001,
        S_BMUL   = 21'h000002,
        S_BDIV   = 21'h000004,
        S_BWAIT  = 21'h000008,
        S_SPLIT  = 21'h000010,
        S_SDIV   = 21'h000020,
        S_SWAIT  = 21'h000040,
        S_SRD    = 21'h000080,
        S_SMDIV  = 21'h000100,
        S_SMWAIT = 21'h000200,
        S_AMUL   = 21'h000400,
        S_ADIV   = 21'h000800,
        S_AWAIT  = 21'h001000,
        S_EUC    = 21'h002000,
        S_EDIV   = 21'h004000,
        S_EWAIT  = 21'h008000,
        S_EUS    = 21'h010000,
        S_FMUL   = 21'h020000,
        S_FDIV   = 21'h040000,
        S_FWAIT  = 21'h080000,
        S_FIN    = 21'h100000
    } state_t;

    state_t state_reg, state_next;

    logic [bmp_pkg::RES_W-1:0]  modulus_reg;
    logic                       table_ready_reg;
    logic [bmp_pkg::ARG_W-1:0]  n_reg, k_reg, m_reg;
    logic [bmp_pkg::RES_W-1:0]  r_reg, a1_reg, a2_reg, acc_reg, rd_reg, res_reg;
    logic [bmp_pkg::ARG_W-1:0]  e_reg, e1_reg;
    logic [bmp_pkg::ARG_W:0]    e23_reg;
    logic [1:0]                 sel_reg;
    logic [IW-1:0]              bld_i_reg;
    logic [bmp_pkg::ARG_W-1:0]  prod_reg;
    logic                       qodd_reg, rd_ok_reg;
    logic [bmp_pkg::RES_W-1:0]  r0_reg, r1_reg, q_reg;
    logic signed [SW-1:0]       s0_reg, s1_reg;
    logic                       out_valid_reg;
    logic [bmp_pkg::RES_W-1:0]  out_data_reg;

    logic [bmp_pkg::RES_W-1:0]  fact_mem [TABLE_DEPTH];

    // divider hookup
    logic                       div_start;
    logic [bmp_pkg::ARG_W-1:0]  div_n;
    logic [bmp_pkg::RES_W-1:0]  div_d;
    logic [bmp_pkg::ARG_W-1:0]  div_q;
    logic [bmp_pkg::RES_W-1:0]  div_r;
    logic                       div_done;

    bmp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quot     (div_q),
        .rem      (div_r),
        .done     (div_done)
    );

    assign div_start = (state_reg == S_BDIV) || (state_reg == S_SDIV) ||
                       (state_reg == S_SMDIV) || (state_reg == S_ADIV) ||
                       (state_reg == S_EDIV) || (state_reg == S_FDIV);
    assign div_n     = (state_reg == S_SDIV) ? m_reg :
                       (state_reg == S_EDIV) ? {{(bmp_pkg::ARG_W-bmp_pkg::RES_W){1'b0}}, r0_reg} :
                       prod_reg;
    assign div_d     = (state_reg == S_EDIV) ? r1_reg : modulus_reg;

    // table addressing
    logic [XW-1:0]              bld_ext, rd_ext;
    logic                       bld_end;
    logic [bmp_pkg::RES_W-1:0]  f_raw, f_val;

    assign bld_ext = {{AW{1'b0}}, bld_i_reg};
    assign rd_ext  = {{(AW+1){1'b0}}, div_r};
    assign bld_end = (bld_i_reg == {1'b0, modulus_reg}) || (bld_ext >= XW'(TABLE_DEPTH));
    assign f_raw   = rd_ok_reg ? rd_reg : '0;
    // Wilson: odd quotient negates the factor
    assign f_val   = (qodd_reg && (f_raw != '0)) ? (modulus_reg - f_raw) : f_raw;

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_BWAIT) && div_done)
            fact_mem[bld_ext[AW-1:0]] <= div_r;
        rd_reg <= fact_mem[rd_ext[AW-1:0]];
    end

    // shared unsigned multiplier
    logic [IW-1:0]              mul_a;
    logic [bmp_pkg::RES_W-1:0]  mul_b;
    logic [IW+bmp_pkg::RES_W-1:0] mul_p;
    logic signed [SW-1:0]       pm, x_fix;
    logic signed [SW+bmp_pkg::RES_W:0] qs;

    assign pm = SW'({2'b00, modulus_reg});
    always_comb
    begin
        if ((s0_reg == pm) || (s0_reg == -pm))
            x_fix = '0;
        else if (s0_reg < 0)
            x_fix = s0_reg + pm;
        else
            x_fix = s0_reg;
    end

    always_comb
    begin
        unique case (state_reg)
            S_BMUL:
            begin
                mul_a = (bld_i_reg == '0) ? IW'(1) : bld_i_reg;
                mul_b = acc_reg;
            end
            S_SRD:
            begin
                mul_a = {1'b0, r_reg};
                mul_b = f_val;
            end
            S_AMUL:
            begin
                mul_a = {1'b0, a2_reg};
                mul_b = r_reg;
            end
            default:
            begin
                mul_a = {1'b0, a1_reg};
                mul_b = x_fix[bmp_pkg::RES_W-1:0];
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;
    assign qs    = $signed({1'b0, q_reg}) * s1_reg;

    logic in_fire, bad_args;
    assign in_req.ready = (state_reg == S_IDLE);
    assign in_fire      = in_req.valid && in_req.ready;
    assign bad_args     = (modulus_reg < 16'd2) || in_req.top_n[bmp_pkg::ARG_W-1] ||
                          in_req.choose_k[bmp_pkg::ARG_W-1] ||
                          ($unsigned(in_req.choose_k) > $unsigned(in_req.top_n));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    if (bad_args)
                        state_next = S_FIN;
                    else if (table_ready_reg)
                        state_next = S_SPLIT;
                    else
                        state_next = S_BMUL;
                end
            S_BMUL:   state_next = bld_end ? S_SPLIT : S_BDIV;
            S_BDIV:   state_next = S_BWAIT;
            S_BWAIT:  if (div_done) state_next = S_BMUL;
            S_SPLIT:
                if (m_reg != '0)
                    state_next = S_SDIV;
                else if (sel_reg == 2'd2)
                    state_next = S_AMUL;
            S_SDIV:   state_next = S_SWAIT;
            S_SWAIT:  if (div_done) state_next = S_SRD;
            S_SRD:    state_next = S_SMDIV;
            S_SMDIV:  state_next = S_SMWAIT;
            S_SMWAIT: if (div_done) state_next = S_SPLIT;
            S_AMUL:   state_next = ({1'b0, e1_reg} > e23_reg) ? S_FIN : S_ADIV;
            S_ADIV:   state_next = S_AWAIT;
            S_AWAIT:  if (div_done) state_next = S_EUC;
            S_EUC:    state_next = (r1_reg == '0) ? S_FMUL : S_EDIV;
            S_EDIV:   state_next = S_EWAIT;
            S_EWAIT:  if (div_done) state_next = S_EUS;
            S_EUS:    state_next = S_EUC;
            S_FMUL:   state_next = S_FDIV;
            S_FDIV:   state_next = S_FWAIT;
            S_FWAIT:  if (div_done) state_next = S_FIN;
            S_FIN:    if (!out_valid_reg || out_rsp.ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            modulus_reg     <= bmp_pkg::MODULUS_RESET;
            table_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                modulus_reg     <= cfg_wdata;
                table_ready_reg <= 1'b0;
            end
            else if ((state_reg == S_BMUL) && bld_end)
                table_ready_reg <= 1'b1;
            if ((state_reg == S_FIN) && (!out_valid_reg || out_rsp.ready))
                out_valid_reg <= 1'b1;
            else if (out_rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                n_reg     <= in_req.top_n;
                k_reg     <= in_req.choose_k;
                m_reg     <= in_req.top_n;
                sel_reg   <= 2'd0;
                r_reg     <= 16'd1;
                e_reg     <= '0;
                e23_reg   <= '0;
                bld_i_reg <= '0;
                acc_reg   <= 16'd1;
                res_reg   <= '0;
            end
            S_BMUL:   prod_reg <= mul_p[bmp_pkg::ARG_W-1:0];
            S_BWAIT:
                if (div_done)
                begin
                    acc_reg   <= div_r;
                    bld_i_reg <= bld_i_reg + 1'b1;
                end
            S_SPLIT:
                if (m_reg == '0)
                begin
                    case (sel_reg)
                        2'd0:
                        begin
                            a1_reg <= r_reg;
                            e1_reg <= e_reg;
                            m_reg  <= k_reg;
                            r_reg  <= 16'd1;
                        end
                        2'd1:
                        begin
                            a2_reg  <= r_reg;
                            e23_reg <= {1'b0, e_reg};
                            m_reg   <= n_reg - k_reg;
                            r_reg   <= 16'd1;
                        end
                        default:
                            e23_reg <= e23_reg + {1'b0, e_reg};
                    endcase
                    e_reg   <= '0;
                    sel_reg <= sel_reg + 1'b1;
                end
            S_SWAIT:
                if (div_done)
                begin
                    e_reg     <= e_reg + div_q;
                    m_reg     <= div_q;
                    qodd_reg  <= div_q[0];
                    rd_ok_reg <= (rd_ext < XW'(TABLE_DEPTH));
                end
            S_SRD:    prod_reg <= mul_p[bmp_pkg::ARG_W-1:0];
            S_SMWAIT: if (div_done) r_reg <= div_r;
            S_AMUL:   prod_reg <= mul_p[bmp_pkg::ARG_W-1:0];
            S_AWAIT:
                if (div_done)
                begin
                    r0_reg <= div_r;
                    r1_reg <= modulus_reg;
                    s0_reg <= SW'(1);
                    s1_reg <= '0;
                end
            S_EWAIT:
                if (div_done)
                begin
                    q_reg  <= div_q[bmp_pkg::RES_W-1:0];
                    r0_reg <= r1_reg;
                    r1_reg <= div_r;
                end
            S_EUS:
            begin
                s0_reg <= s1_reg;
                s1_reg <= SW'(s0_reg - qs);
            end
            S_FMUL:   prod_reg <= mul_p[bmp_pkg::ARG_W-1:0];
            S_FWAIT:  if (div_done) res_reg <= div_r;
            S_FIN:    if (!out_valid_reg || out_rsp.ready) out_data_reg <= res_reg;
            default:  ;
        endcase
    end

    assign out_rsp.valid            = out_valid_reg;
    assign out_rsp.binomial_residue = out_data_reg;

`ifndef SYNTHESIS
    a_ready_lost: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(table_ready_reg) |-> $past(cfg_wen))
        else $error("table marked stale without a modulus write");
    a_cfg_stale: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wen |=> !table_ready_reg)
        else $error("table still marked ready after modulus write");
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_rsp.valid |-> (out_rsp.binomial_residue == '0 ||
                           out_rsp.binomial_residue < modulus_reg))
        else $error("result not reduced modulo p");
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> !div_done)
        else $error("divider finished straight after start");
`endif

endmodule

@@ sv/bmp_div.sv @@
// Shared restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
module bmp_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bmp_pkg::ARG_W-1:0]   dividend,
    input  logic [bmp_pkg::RES_W-1:0]   divisor,
    output logic [bmp_pkg::ARG_W-1:0]   quot,
    output logic [bmp_pkg::RES_W-1:0]   rem,
    output logic                        done
);

    localparam int unsigned CW = $clog2(bmp_pkg::ARG_W);

    logic [bmp_pkg::ARG_W-1:0] quot_reg;
    logic [bmp_pkg::RES_W-1:0] rem_reg;
    logic [bmp_pkg::RES_W-1:0] dvs_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [bmp_pkg::RES_W:0]   shifted;
    logic [bmp_pkg::RES_W+1:0] diff;

    assign shifted = {rem_reg, quot_reg[bmp_pkg::ARG_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(bmp_pkg::ARG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[bmp_pkg::ARG_W-2:0], ~diff[bmp_pkg::RES_W+1]};
            if (!diff[bmp_pkg::RES_W+1])
                rem_reg <= diff[bmp_pkg::RES_W-1:0];
            else
                rem_reg <= shifted[bmp_pkg::RES_W-1:0];
        end
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule
